>>> rtl/core/abr_pkg.sv
// ----------------------------------------------------------------------------
// abr_pkg
// Shared types, constants and helpers of the adaptive bitrate recommender.
// ----------------------------------------------------------------------------
package abr_pkg;

	localparam int RATE_W  = 34;
	localparam int LOSS_W  = 17;
	localparam int RTT_W   = 24;
	localparam int BUF_W   = 32;
	// operand width of the divide-by-five units (largest is target times 19)
	localparam int DIV_W   = RATE_W + 5;
	// register stages inside one divide-by-five unit
	localparam int DIV_LAT = 3;

	localparam logic [RATE_W-1:0] MIN_RATE_RST = 34'd500000;
	localparam logic [RATE_W-1:0] MAX_RATE_RST = 34'd8000000;

	localparam logic [LOSS_W-1:0] LOSS_HEAVY_TH = 17'd5000;
	localparam logic [LOSS_W-1:0] LOSS_MID_TH   = 17'd2000;
	localparam logic [LOSS_W-1:0] LOSS_LIGHT_TH = 17'd500;
	localparam logic [RTT_W-1:0]  RTT_HEAVY_TH  = 24'd300000;
	localparam logic [RTT_W-1:0]  RTT_LIGHT_TH  = 24'd200000;

	typedef enum logic {
		REG_MIN_RATE,
		REG_MAX_RATE
	} abr_reg_t;

	typedef enum logic [1:0] {
		SCL_NONE,
		SCL_LIGHT,
		SCL_MID,
		SCL_HEAVY
	} abr_scl_t;

	typedef struct packed {
		logic                up;
		abr_scl_t            rtt_sel;
		logic                buf_hit;
	} abr_flags_t;

	typedef struct packed {
		logic [RATE_W:0]     hi;
		logic [RATE_W-1:0]   lo;
		logic                up;
	} abr_bnd_t;

	typedef struct packed {
		abr_bnd_t            bnd;
		logic                buf_hit;
	} abr_side_t;

	// quotient fix-up for a small remainder left by the estimate
	function automatic logic [3:0] div5_fix(input logic [5:0] r);
		logic [3:0] c;
		c = '0;
		for (int k = 1; k <= 12; k++) begin
			if (r >= 6'(5 * k))
				c = c + 4'd1;
		end
		return c;
	endfunction

endpackage

>>> rtl/core/adaptive_bitrate_recommender.sv
// ----------------------------------------------------------------------------
// adaptive_bitrate_recommender
// Recommends a bitrate from one link-statistics sample and the rate in use.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle while results are being taken. The
// pipeline is one input stage, three chained divide-by-five units of three
// stages each (loss, round trip and buffer scaling, the rate limits riding
// along in the first), each behind its own numerator register, a limit stage
// and the output register. All stages advance together, so the only stall is
// a result held in the output register that the sink has not taken. min_rate
// and max_rate are written through the cfg port; the user must write them only
// while no sample is in flight, which the block itself does not enforce.
module adaptive_bitrate_recommender import abr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [RATE_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              link_up,
	input  logic [RATE_W-1:0] bandwidth_bps,
	input  logic [LOSS_W-1:0] loss_milli_pct,
	input  logic [RTT_W-1:0]  rtt_us,
	input  logic [BUF_W-1:0]  buf_free_bytes,
	input  logic [BUF_W-1:0]  buf_size_bytes,
	input  logic [RATE_W-1:0] current_rate,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [RATE_W-1:0] recommended_rate
);

	logic              adv;
	logic [RATE_W-1:0] min_rate_q, max_rate_q;

	// input stage
	logic [RATE_W+1:0] bw3, bfree10;
	abr_scl_t          loss_sel, rtt_sel;
	logic              v_s1;
	logic [RATE_W-1:0] t0_s1, cur_s1;
	abr_scl_t          loss_sel_s1;
	abr_flags_t        flags_s1;

	// loss numerator and rate limit numerators
	logic [4:0]        l_num;
	logic [1:0]        l_sh;
	logic [DIV_W-1:0]  l_prod, cur6, cur7;
	logic              v_s2;
	logic [DIV_W-1:0]  nl_s2, nh_s2, nlo_s2;
	abr_flags_t        flags_s2;

	logic [DIV_W-1:0]  ql, qh, qlo;
	logic              v_g1;
	abr_flags_t        flags_g1;

	// rtt numerator
	logic [4:0]        r_num;
	logic [1:0]        r_sh;
	logic [DIV_W-1:0]  r_prod;
	logic              v_s6;
	logic [DIV_W-1:0]  nr_s6;
	abr_side_t         side_s6;

	logic [DIV_W-1:0]  qr;
	logic              v_g2;
	abr_side_t         side_g2;

	// buffer numerator
	logic [DIV_W-1:0]  b_prod;
	logic              v_s10;
	logic [DIV_W-1:0]  nb_s10;
	abr_bnd_t          bnd_s10;

	logic [DIV_W-1:0]  qb;
	logic              v_g3;
	abr_bnd_t          bnd_g3;

	// limit and clamp
	logic [RATE_W-1:0] t3;
	logic [RATE_W:0]   t4, tm;
	logic              v_s14, up_s14;
	logic [RATE_W:0]   t4_s14;
	logic              v_s15;
	logic [RATE_W-1:0] out_s15;

	assign adv      = !v_s15 || out_ready;
	assign in_ready = adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rate_q <= MIN_RATE_RST;
			max_rate_q <= MAX_RATE_RST;
		end else if (cfg_we) begin
			unique case (abr_reg_t'(cfg_idx))
				REG_MIN_RATE: min_rate_q <= cfg_wdata;
				REG_MAX_RATE: max_rate_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage 1: base target, step selection, buffer test
	always_comb begin
		bw3     = {2'b00, bandwidth_bps} + {1'b0, bandwidth_bps, 1'b0};
		bfree10 = {1'b0, buf_free_bytes, 3'b000} + {3'b000, buf_free_bytes, 1'b0};
		if (loss_milli_pct > LOSS_HEAVY_TH)
			loss_sel = SCL_HEAVY;
		else if (loss_milli_pct > LOSS_MID_TH)
			loss_sel = SCL_MID;
		else if (loss_milli_pct > LOSS_LIGHT_TH)
			loss_sel = SCL_LIGHT;
		else
			loss_sel = SCL_NONE;
		if (rtt_us > RTT_HEAVY_TH)
			rtt_sel = SCL_HEAVY;
		else if (rtt_us > RTT_LIGHT_TH)
			rtt_sel = SCL_LIGHT;
		else
			rtt_sel = SCL_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s6  <= 1'b0;
			v_s10 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else if (adv) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s6  <= v_g1;
			v_s10 <= v_g2;
			v_s14 <= v_g3;
			v_s15 <= v_s14;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t0_s1            <= bw3[RATE_W+1:2];
			cur_s1           <= current_rate;
			loss_sel_s1      <= loss_sel;
			flags_s1.up      <= link_up;
			flags_s1.rtt_sel <= rtt_sel;
			flags_s1.buf_hit <= (buf_size_bytes != '0) &&
				(bfree10 < {4'b0000, buf_size_bytes});
		end
	end

	// stage 2: every scale is (x * num) >> sh, then divided by five
	always_comb begin
		case (loss_sel_s1)
			SCL_HEAVY: begin l_num = 5'd7;  l_sh = 2'd1; end
			SCL_MID:   begin l_num = 5'd17; l_sh = 2'd2; end
			SCL_LIGHT: begin l_num = 5'd19; l_sh = 2'd2; end
			default:   begin l_num = 5'd5;  l_sh = 2'd0; end
		endcase
		l_prod = DIV_W'(t0_s1) * DIV_W'(l_num);
		cur6   = {3'b000, cur_s1, 2'b00} + {4'b0000, cur_s1, 1'b0};
		cur7   = {2'b00, cur_s1, 3'b000} - {5'b00000, cur_s1};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nl_s2    <= l_prod >> l_sh;
			nh_s2    <= cur6;
			nlo_s2   <= cur7 >> 1;
			flags_s2 <= flags_s1;
		end
	end

	abr_div5 #(.W(DIV_W)) u_div_loss (.clk(clk), .en(adv), .n(nl_s2), .q(ql));
	abr_div5 #(.W(DIV_W)) u_div_hi   (.clk(clk), .en(adv), .n(nh_s2), .q(qh));
	abr_div5 #(.W(DIV_W)) u_div_lo   (.clk(clk), .en(adv), .n(nlo_s2), .q(qlo));

	abr_delay #(.W($bits(abr_flags_t)), .DEPTH(DIV_LAT)) u_dly_loss (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.vld_in(v_s2), .d(flags_s2), .vld_out(v_g1), .q(flags_g1)
	);

	// stage 6: rtt numerator
	always_comb begin
		case (flags_g1.rtt_sel)
			SCL_HEAVY: begin r_num = 5'd9;  r_sh = 2'd1; end
			SCL_LIGHT: begin r_num = 5'd19; r_sh = 2'd2; end
			default:   begin r_num = 5'd5;  r_sh = 2'd0; end
		endcase
		r_prod = DIV_W'(ql[RATE_W-1:0]) * DIV_W'(r_num);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nr_s6           <= r_prod >> r_sh;
			side_s6.bnd.hi  <= qh[RATE_W:0];
			side_s6.bnd.lo  <= qlo[RATE_W-1:0];
			side_s6.bnd.up  <= flags_g1.up;
			side_s6.buf_hit <= flags_g1.buf_hit;
		end
	end

	abr_div5 #(.W(DIV_W)) u_div_rtt (.clk(clk), .en(adv), .n(nr_s6), .q(qr));

	abr_delay #(.W($bits(abr_side_t)), .DEPTH(DIV_LAT)) u_dly_rtt (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.vld_in(v_s6), .d(side_s6), .vld_out(v_g2), .q(side_g2)
	);

	// stage 10: buffer numerator, 4 when the buffer is nearly full
	assign b_prod = side_g2.buf_hit ? {3'b000, qr[RATE_W-1:0], 2'b00} :
		({3'b000, qr[RATE_W-1:0], 2'b00} + DIV_W'(qr[RATE_W-1:0]));

	always_ff @(posedge clk) begin
		if (adv) begin
			nb_s10  <= b_prod;
			bnd_s10 <= side_g2.bnd;
		end
	end

	abr_div5 #(.W(DIV_W)) u_div_buf (.clk(clk), .en(adv), .n(nb_s10), .q(qb));

	abr_delay #(.W($bits(abr_bnd_t)), .DEPTH(DIV_LAT)) u_dly_buf (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.vld_in(v_s10), .d(bnd_s10), .vld_out(v_g3), .q(bnd_g3)
	);

	// stage 14: rate limit; hi is never below current rate and lo never above
	always_comb begin
		t3 = qb[RATE_W-1:0];
		if ({1'b0, t3} > bnd_g3.hi)
			t4 = bnd_g3.hi;
		else if (t3 < bnd_g3.lo)
			t4 = {1'b0, bnd_g3.lo};
		else
			t4 = {1'b0, t3};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t4_s14 <= t4;
			up_s14 <= bnd_g3.up;
		end
	end

	// stage 15: clamp to min then max, or min when the link is down
	assign tm = (t4_s14 < {1'b0, min_rate_q}) ? {1'b0, min_rate_q} : t4_s14;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!up_s14)
				out_s15 <= min_rate_q;
			else if (tm > {1'b0, max_rate_q})
				out_s15 <= max_rate_q;
			else
				out_s15 <= tm[RATE_W-1:0];
		end
	end

	assign out_valid        = v_s15;
	assign recommended_rate = out_s15;

	// a result is either within max_rate or the link-down minimum
	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (recommended_rate <= max_rate_q) ||
			(recommended_rate == min_rate_q))
		else $error("recommended rate above max_rate");

	// an empty output register never blocks the input side
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	// an accepted transaction always enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted transaction lost at first stage");

endmodule

>>> rtl/core/abr_div5.sv
// ----------------------------------------------------------------------------
// abr_div5
// Three-stage unsigned divide by five: shift-add reciprocal estimate,
// then a remainder based correction.
// ----------------------------------------------------------------------------
module abr_div5 import abr_pkg::*; #(
	parameter int W = DIV_W
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] n,
	output logic [W-1:0] q
);

	logic [W-1:0] a, b, c, d, e, qe;
	logic [5:0]   qe5, r;

	logic [W-1:0] b_s1;
	logic [W-1:0] d_s2;
	logic [5:0]   nl_s1, nl_s2;
	logic [W-1:0] q_s3;

	// estimate never exceeds the true quotient and trails it by at most two
	always_comb begin
		a = (n >> 1) + (n >> 2);
		b = a + (a >> 4);
		c = b_s1 + (b_s1 >> 8);
		d = c + (c >> 16);
		e = d_s2 + (d_s2 >> 32);
		qe = e >> 2;
		qe5 = {qe[3:0], 2'b00} + qe[5:0];
		r = nl_s2 - qe5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s1  <= b;
			nl_s1 <= n[5:0];
			d_s2  <= d;
			nl_s2 <= nl_s1;
			q_s3  <= qe + W'(div5_fix(r));
		end
	end

	assign q = q_s3;

endmodule

>>> rtl/core/abr_delay.sv
// ----------------------------------------------------------------------------
// abr_delay
// Valid bit and sideband delay line that runs beside a divide unit.
// ----------------------------------------------------------------------------
module abr_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 3
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         vld_in,
	input  logic [W-1:0] d,
	output logic         vld_out,
	output logic [W-1:0] q
);

	logic [DEPTH-1:0] vld_q;
	logic [W-1:0]     dat_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q[0] <= vld_in;
			for (int i = 1; i < DEPTH; i++)
				vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_q[0] <= d;
			for (int i = 1; i < DEPTH; i++)
				dat_q[i] <= dat_q[i-1];
		end
	end

	assign vld_out = vld_q[DEPTH-1];
	assign q       = dat_q[DEPTH-1];

endmodule
